[rtl/lsfp_pkg.sv]
`default_nettype none

package lsfp_pkg;

    // frame geometry
    localparam int FRAME_BYTES = 5;
    localparam int STORE_BYTES = FRAME_BYTES - 1;
    localparam int STORE_IDX_W = $clog2(STORE_BYTES);
    localparam int BYTE_POS_W  = $clog2(FRAME_BYTES);

    // point limit default and bias reset
    localparam int DEF_MAX_POINTS = 1024;
    localparam logic [15:0] BIAS_RESET = 16'd1068;

    // result field widths
    localparam int QUALITY_W = 6;
    localparam int ANGLE_W   = 15;
    localparam int DIST_W    = 16;
    localparam int INDEX_W   = 10;
    localparam int COUNT_W   = 11;

    // output stream layout
    localparam int FIELDS_W = QUALITY_W + ANGLE_W + DIST_W + INDEX_W + COUNT_W;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - FIELDS_W;

    // result queue depth
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic
    {
        KIND_POINT  = 1'b0,
        KIND_MARKER = 1'b1
    } lsfp_kind_t;

    typedef struct packed
    {
        lsfp_kind_t           kind;
        logic [QUALITY_W-1:0] quality;
        logic [ANGLE_W-1:0]   angle_deg64;
        logic [DIST_W-1:0]    distance_q4mm;
        logic [INDEX_W-1:0]   point_index;
        logic [COUNT_W-1:0]   scan_points;
        logic                 last_of_run;
    } lsfp_result_t;

    // write request from the parser into the result queue
    typedef struct packed
    {
        logic [1:0]   num;
        lsfp_result_t r1;
        lsfp_result_t r0;
    } lsfp_wr_t;

endpackage

`default_nettype wire

[rtl/lsfp_parser.sv]
`default_nettype none

module lsfp_parser #(
    parameter int MAX_POINTS = lsfp_pkg::DEF_MAX_POINTS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,
    input  wire logic [15:0]         bias,
    input  wire logic                fifo_space,
    output lsfp_pkg::lsfp_wr_t       wr
);
    import lsfp_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic [BYTE_POS_W-1:0] byte_pos_reg, byte_pos_next;
    logic [7:0]            frame_reg [STORE_BYTES];
    logic [CNT_W-1:0]      points_reg, points_next;

    logic                  advance;
    logic                  start_ok;
    logic                  frame_end;
    logic                  store_byte;
    logic                  marker;
    logic                  keep;
    logic [CNT_W-1:0]      pts_base;
    logic [DIST_W-1:0]     raw_dist;
    logic [31:0]           idx_ext;
    logic [31:0]           cnt_ext;
    lsfp_result_t          point_res;
    lsfp_result_t          marker_res;

    // input register
    assign advance  = in_valid_reg && fifo_space;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // frame decode
    always_comb
    begin
        start_ok   = (byte_pos_reg != '0) || (in_byte_reg[0] != in_byte_reg[1]);
        frame_end  = (byte_pos_reg == BYTE_POS_W'(STORE_BYTES));
        store_byte = advance && start_ok && !frame_end;
        marker     = frame_reg[0][0] && (points_reg != '0);
        pts_base   = marker ? '0 : points_reg;
        raw_dist   = {in_byte_reg, frame_reg[3]};
        keep       = frame_reg[1][0] && (pts_base < MAX_CNT)
                     && (raw_dist != '0) && (raw_dist > bias);
        idx_ext    = 32'(pts_base);
        cnt_ext    = 32'(points_reg);
    end

    // result candidates
    always_comb
    begin
        point_res               = '0;
        point_res.kind          = KIND_POINT;
        point_res.quality       = frame_reg[0][7:2];
        point_res.angle_deg64   = {frame_reg[2], frame_reg[1][7:1]};
        point_res.distance_q4mm = raw_dist - bias;
        point_res.point_index   = idx_ext[INDEX_W-1:0];
        point_res.last_of_run   = 1'b1;

        marker_res              = '0;
        marker_res.kind         = KIND_MARKER;
        marker_res.scan_points  = cnt_ext[COUNT_W-1:0];
        marker_res.last_of_run  = !keep;
    end

    // queue write request
    always_comb
    begin
        wr     = '0;
        wr.r0  = marker ? marker_res : point_res;
        wr.r1  = point_res;
        if (advance && frame_end)
        begin
            wr.num = {1'b0, marker} + {1'b0, keep};
        end
    end

    // parser state next values
    always_comb
    begin
        byte_pos_next = byte_pos_reg;
        points_next   = points_reg;
        if (advance && frame_end)
        begin
            byte_pos_next = '0;
            points_next   = keep ? pts_base + 1'b1 : pts_base;
        end
        else if (store_byte)
        begin
            byte_pos_next = byte_pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg <= '0;
            points_reg   <= '0;
        end
        else
        begin
            byte_pos_reg <= byte_pos_next;
            points_reg   <= points_next;
        end
    end

    // frame byte store
    always_ff @(posedge clk)
    begin
        if (store_byte)
        begin
            frame_reg[byte_pos_reg[STORE_IDX_W-1:0]] <= in_byte_reg;
        end
    end

endmodule

`default_nettype wire

[rtl/lsfp_result_fifo.sv]
`default_nettype none

module lsfp_result_fifo (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lsfp_pkg::lsfp_wr_t    wr,
    output logic                       space,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output lsfp_pkg::lsfp_result_t     head
);
    import lsfp_pkg::*;

    lsfp_result_t          mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wptr_reg, wptr_next;
    logic [FIFO_PTR_W-1:0] rptr_reg, rptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  rd;

    // status
    assign m_tvalid = (count_reg != '0);
    assign space    = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign head     = mem[rptr_reg];
    assign rd       = m_tvalid && m_tready;

    // pointer and count next values
    always_comb
    begin
        wptr_next  = wptr_reg + FIFO_PTR_W'(wr.num);
        rptr_next  = rptr_reg + FIFO_PTR_W'(rd);
        count_next = count_reg + FIFO_CNT_W'(wr.num) - FIFO_CNT_W'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // entry storage, up to two writes a cycle
    always_ff @(posedge clk)
    begin
        if (wr.num != 2'd0)
        begin
            mem[wptr_reg] <= wr.r0;
        end
        if (wr.num == 2'd2)
        begin
            mem[wptr_reg + 1'b1] <= wr.r1;
        end
    end

endmodule

`default_nettype wire

[rtl/lidar_scan_frame_parser_top.sv]
// channel   direction  handshake               payload
// cfg       in         cfg_valid / cfg_ready   cfg_data: distance_bias_q2
// s         in         s_tvalid / s_tready     s_tdata: rx_byte
// m         out        m_tvalid / m_tready     m_tdata, m_tuser, m_tlast
//
// one byte accepted per cycle while the result queue has space; a frame's
// results pass through the input register and then the result queue
// reset is asynchronous and active low; no clearing pass is needed
// a frame-ending byte may cause two results, drained one per cycle while
// m_tready is high from a four-entry result queue; input stalls only while
// that queue holds more than two results
`default_nettype none

module lidar_scan_frame_parser_top #(
    parameter int MAX_POINTS = lsfp_pkg::DEF_MAX_POINTS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [15:0]                   cfg_data,   // distance_bias_q2
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,    // rx_byte
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // quality, angle_deg64, distance_q4mm, point_index, scan_points, zero pad
    output logic [lsfp_pkg::TDATA_W-1:0]       m_tdata,
    output logic                               m_tuser,    // result_kind
    output logic                               m_tlast     // last_of_run
);
    import lsfp_pkg::*;

    logic [15:0]  bias_reg;
    logic         fifo_space;
    lsfp_wr_t     wr;
    lsfp_result_t head;

    // bias register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg <= BIAS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            bias_reg <= cfg_data;
        end
    end

    // frame parser
    lsfp_parser #(
        .MAX_POINTS (MAX_POINTS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .bias       (bias_reg),
        .fifo_space (fifo_space),
        .wr         (wr)
    );

    // result queue
    lsfp_result_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .space    (fifo_space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    // output packing
    assign m_tdata = {{PAD_W{1'b0}}, head.scan_points, head.point_index,
                      head.distance_q4mm, head.angle_deg64, head.quality};
    assign m_tuser = head.kind;
    assign m_tlast = head.last_of_run;

endmodule

`default_nettype wire

[rtl/lsfp_checker.sv]
`default_nettype none

module lsfp_checker (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    m_tvalid,
    input wire logic                    m_tready,
    input wire logic [lsfp_pkg::TDATA_W-1:0] m_tdata,
    input wire logic                    m_tuser,
    input wire logic                    m_tlast
);
    import lsfp_pkg::*;

    // a marker carries only the point count
    marker_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[46:0] == '0)
        else $error("marker result carries point fields");

    // a point carries no count and no pad bits
    point_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[TDATA_W-1:47] == '0)
        else $error("point result carries scan count");

    // a kept point lies strictly above the bias
    point_dist_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[36:21] != '0)
        else $error("point result with zero distance");

    // stalled result holds
    stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
        && $stable(m_tuser) && $stable(m_tlast))
        else $error("output changed under stall");

endmodule

bind lidar_scan_frame_parser_top lsfp_checker u_lsfp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

[tb/lidar_scan_frame_parser_top_tb.sv]
`timescale 1ns / 1ps

module lidar_scan_frame_parser_top_tb;

    import lsfp_pkg::*;

    localparam int SCAN_LIMIT  = DEF_MAX_POINTS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_WAIT  = 8;
    localparam int MAX_REPORTS = 40;

    // start bit pair in a frame head byte: bit 0 start, bit 1 its inverse
    localparam logic [1:0] START_SET   = 2'b01;
    localparam logic [1:0] START_CLEAR = 2'b10;

    // result field offsets in m_tdata
    localparam int Q_LSB = 0;
    localparam int A_LSB = Q_LSB + QUALITY_W;
    localparam int D_LSB = A_LSB + ANGLE_W;
    localparam int I_LSB = D_LSB + DIST_W;
    localparam int C_LSB = I_LSB + INDEX_W;

    // one directed stimulus row, with results typed in where typed is set
    typedef struct packed
    {
        logic [7:0]   rx_byte;
        logic         typed;
        logic [1:0]   num;
        lsfp_result_t r0;
        lsfp_result_t r1;
    } stim_row_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [15:0]         cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    // parser state mirror
    logic [15:0]         bias_q2   = BIAS_RESET;
    logic [2:0]          frame_pos = '0;
    logic [7:0]          frame_bytes [0:3];
    logic [12:0]         scan_count = '0;
    lsfp_result_t        frame_results [0:1];
    int                  frame_result_n;
    lsfp_result_t        pending_results [$];

    // sender and receiver pacing
    stim_row_t           directed_rows [$];
    int                  burst_left    = 0;
    bit                  sender_gaps   = 1'b1;
    int                  hold_requests = 0;
    int                  hold_served   = 0;
    int                  hold_left     = 0;
    int                  pattern_age   = 0;
    logic [31:0]         ready_pattern = '1;
    int                  mismatch_count = 0;
    int                  cycle_count    = 0;

    lidar_scan_frame_parser_top #(
        .MAX_POINTS (SCAN_LIMIT)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic lsfp_result_t mk_point(input logic [QUALITY_W-1:0] q,
                                              input logic [ANGLE_W-1:0] ang,
                                              input logic [DIST_W-1:0] distance,
                                              input logic [INDEX_W-1:0] idx,
                                              input logic last);
        lsfp_result_t r;
        r = '0;
        r.kind          = KIND_POINT;
        r.quality       = q;
        r.angle_deg64   = ang;
        r.distance_q4mm = distance;
        r.point_index   = idx;
        r.last_of_run   = last;
        return r;
    endfunction

    function automatic lsfp_result_t mk_marker(input logic [COUNT_W-1:0] cnt,
                                               input logic last);
        lsfp_result_t r;
        r = '0;
        r.kind        = KIND_MARKER;
        r.scan_points = cnt;
        r.last_of_run = last;
        return r;
    endfunction

    function automatic stim_row_t stim_row(input logic [7:0] b, input logic typed,
                                           input logic [1:0] num,
                                           input lsfp_result_t r0,
                                           input lsfp_result_t r1);
        stim_row_t row;
        row.rx_byte = b;
        row.typed   = typed;
        row.num     = num;
        row.r0      = r0;
        row.r1      = r1;
        return row;
    endfunction

    // frame assembly and point filter for one received byte
    task automatic predict_byte(input logic [7:0] b);
        logic [15:0] raw_dist;
        frame_result_n = 0;
        if (frame_pos == 0 && b[0] == b[1])
            return;
        if (frame_pos < FRAME_BYTES - 1)
        begin
            frame_bytes[frame_pos[1:0]] = b;
            frame_pos = frame_pos + 3'd1;
            return;
        end
        frame_pos = '0;
        // a start frame closes a non-empty scan first
        if (frame_bytes[0][0] && scan_count > 0)
        begin
            frame_results[0] = mk_marker(scan_count[COUNT_W-1:0], 1'b0);
            frame_result_n = 1;
            scan_count = '0;
        end
        raw_dist = {b, frame_bytes[3]};
        if (frame_bytes[1][0] && scan_count < SCAN_LIMIT && raw_dist != 0
            && raw_dist > bias_q2)
        begin
            frame_results[frame_result_n] = mk_point(frame_bytes[0][7:2],
                {frame_bytes[2], frame_bytes[1][7:1]}, raw_dist - bias_q2,
                scan_count[INDEX_W-1:0], 1'b0);
            frame_result_n++;
            scan_count = scan_count + 13'd1;
        end
        if (frame_result_n > 0)
            frame_results[frame_result_n - 1].last_of_run = 1'b1;
    endtask

    // one byte request, then burst and gap pacing
    task automatic drive_byte(input stim_row_t row);
        s_tvalid <= 1'b1;
        s_tdata  <= row.rx_byte;
        do @(posedge clk); while (!s_tready);
        predict_byte(row.rx_byte);
        if (row.typed)
        begin
            if (row.num > 0)
                pending_results.push_back(row.r0);
            if (row.num > 1)
                pending_results.push_back(row.r1);
        end
        else
        begin
            for (int i = 0; i < frame_result_n; i++)
                pending_results.push_back(frame_results[i]);
        end
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 15);
            if (sender_gaps)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    task automatic send_rx(input logic [7:0] b);
        drive_byte(stim_row(b, 1'b0, 2'd0, '0, '0));
    endtask

    task automatic send_frame(input logic [7:0] head, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [15:0] raw_dist);
        send_rx(head);
        send_rx(b1);
        send_rx(b2);
        send_rx(raw_dist[7:0]);
        send_rx(raw_dist[15:8]);
    endtask

    // drain, then write the bias register
    task automatic write_bias(input logic [15:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        bias_q2 = value;
    endtask

    // mostly well-formed frames with random content, some stray bytes
    task automatic random_phase(input int n_bytes);
        int          sent;
        logic [7:0]  head;
        logic [7:0]  b1;
        logic [15:0] raw_dist;
        sent = 0;
        while (sent < n_bytes)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                send_rx(8'($urandom));
                sent++;
            end
            else
            begin
                head = {6'($urandom),
                        ($urandom_range(0, 5) == 0) ? START_SET : START_CLEAR};
                b1 = 8'($urandom);
                b1[0] = ($urandom_range(0, 99) < 85);
                case ($urandom_range(0, 6))
                    0:       raw_dist = '0;
                    1:       raw_dist = bias_q2;
                    2:       raw_dist = bias_q2 + 16'd1;
                    3:       raw_dist = '1;
                    4:       raw_dist = bias_q2 + 16'($urandom_range(1, 400));
                    default: raw_dist = 16'($urandom);
                endcase
                send_frame(head, b1, 8'($urandom), raw_dist);
                sent += FRAME_BYTES;
            end
        end
    endtask

    // one scan of frames that are all kept
    task automatic long_scan(input int frames);
        for (int i = 0; i < frames; i++)
            send_frame({6'($urandom), (i == 0) ? START_SET : START_CLEAR},
                       {7'($urandom), 1'b1}, 8'($urandom),
                       bias_q2 + 16'($urandom_range(1, 65535 - bias_q2)));
    endtask

    task automatic report_mismatch(input string what, input longint got_val,
                                   input longint want_val);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t mismatch on %s: got %0d, expected %0d",
                     $time, what, got_val, want_val);
        mismatch_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin : result_check
        lsfp_result_t got;
        lsfp_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind          = lsfp_kind_t'(m_tuser);
            got.quality       = m_tdata[Q_LSB +: QUALITY_W];
            got.angle_deg64   = m_tdata[A_LSB +: ANGLE_W];
            got.distance_q4mm = m_tdata[D_LSB +: DIST_W];
            got.point_index   = m_tdata[I_LSB +: INDEX_W];
            got.scan_points   = m_tdata[C_LSB +: COUNT_W];
            got.last_of_run   = m_tlast;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", got.kind, -1);
            else
            begin
                want = pending_results.pop_front();
                if (got.kind != want.kind)
                    report_mismatch("result_kind", got.kind, want.kind);
                if (got.quality != want.quality)
                    report_mismatch("quality", got.quality, want.quality);
                if (got.angle_deg64 != want.angle_deg64)
                    report_mismatch("angle_deg64", got.angle_deg64, want.angle_deg64);
                if (got.distance_q4mm != want.distance_q4mm)
                    report_mismatch("distance_q4mm", got.distance_q4mm,
                                    want.distance_q4mm);
                if (got.point_index != want.point_index)
                    report_mismatch("point_index", got.point_index, want.point_index);
                if (got.scan_points != want.scan_points)
                    report_mismatch("scan_points", got.scan_points, want.scan_points);
                if (got.last_of_run != want.last_of_run)
                    report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
                if (m_tdata[TDATA_W-1:FIELDS_W] != '0)
                    report_mismatch("tdata pad", m_tdata[TDATA_W-1:FIELDS_W], 0);
            end
        end
    end

    // receiver: rotating stall pattern, plus long hold-off on request
    always @(posedge clk)
    begin : sink_pacing
        if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
        begin
            if (pattern_age == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern = '1;
                    1:       ready_pattern = $urandom;
                    2:       ready_pattern = $urandom | $urandom;
                    default: ready_pattern = ($urandom & $urandom) | 32'h1;
                endcase
                pattern_age = 40;
            end
            m_tready <= ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
            pattern_age--;
        end
    end

    // run limit
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rejected heads both ways
        directed_rows.push_back(stim_row(8'h00, 1'b1, 2'd0, '0, '0));
        directed_rows.push_back(stim_row(8'hFF, 1'b1, 2'd0, '0, '0));
        // all-ones frame: widest quality, angle and distance
        directed_rows.push_back(stim_row(8'hFD, 1'b0, 2'd0, '0, '0));
        directed_rows.push_back(stim_row(8'hFF, 1'b0, 2'd0, '0, '0));
        directed_rows.push_back(stim_row(8'hFF, 1'b0, 2'd0, '0, '0));
        directed_rows.push_back(stim_row(8'hFF, 1'b0, 2'd0, '0, '0));
        directed_rows.push_back(stim_row(8'hFF, 1'b1, 2'd1,
            mk_point(6'd63, 15'd32767, 16'd64467, 10'd0, 1'b1), '0));
        // check bit clear
        directed_rows.push_back(stim_row(8'h02, 1'b0, 2'd0, '0, '0));
        directed_rows.push_back(stim_row(8'h00, 1'b0, 2'd0, '0, '0));
        directed_rows.push_back(stim_row(8'h00, 1'b0, 2'd0, '0, '0));
        directed_rows.push_back(stim_row(8'hFF, 1'b0, 2'd0, '0, '0));
        directed_rows.push_back(stim_row(8'hFF, 1'b1, 2'd0, '0, '0));
        // zero distance
        directed_rows.push_back(stim_row(8'h02, 1'b0, 2'd0, '0, '0));
        directed_rows.push_back(stim_row(8'h01, 1'b0, 2'd0, '0, '0));
        directed_rows.push_back(stim_row(8'h00, 1'b0, 2'd0, '0, '0));
        directed_rows.push_back(stim_row(8'h00, 1'b0, 2'd0, '0, '0));
        directed_rows.push_back(stim_row(8'h00, 1'b1, 2'd0, '0, '0));
        // distance equal to the bias
        directed_rows.push_back(stim_row(8'h02, 1'b0, 2'd0, '0, '0));
        directed_rows.push_back(stim_row(8'h01, 1'b0, 2'd0, '0, '0));
        directed_rows.push_back(stim_row(8'h00, 1'b0, 2'd0, '0, '0));
        directed_rows.push_back(stim_row(8'h2C, 1'b0, 2'd0, '0, '0));
        directed_rows.push_back(stim_row(8'h04, 1'b1, 2'd0, '0, '0));
        // start frame closes the scan, then one above the bias
        directed_rows.push_back(stim_row(8'h01, 1'b0, 2'd0, '0, '0));
        directed_rows.push_back(stim_row(8'h01, 1'b0, 2'd0, '0, '0));
        directed_rows.push_back(stim_row(8'h00, 1'b0, 2'd0, '0, '0));
        directed_rows.push_back(stim_row(8'h2D, 1'b0, 2'd0, '0, '0));
        directed_rows.push_back(stim_row(8'h04, 1'b1, 2'd2,
            mk_marker(11'd1, 1'b0), mk_point(6'd0, 15'd0, 16'd1, 10'd0, 1'b1)));
        foreach (directed_rows[i])
            drive_byte(directed_rows[i]);

        // random phases over several bias settings
        write_bias(16'd0);
        sender_gaps = 1'b1;
        random_phase(60);

        write_bias(16'hFFFF);
        sender_gaps = 1'b0;
        random_phase(40);

        write_bias(16'($urandom));
        sender_gaps = 1'b1;
        random_phase(60);

        // back-to-back kept frames under a long receiver hold-off
        write_bias(BIAS_RESET);
        sender_gaps = 1'b0;
        hold_requests++;
        long_scan(20);
        sender_gaps = 1'b1;
        random_phase(70);

        write_bias(16'($urandom_range(0, 2000)));
        random_phase(50);

        // drain and settle
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT * 2) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
rtl/lsfp_pkg.sv
rtl/lsfp_parser.sv
rtl/lsfp_result_fifo.sv
rtl/lidar_scan_frame_parser_top.sv
rtl/lsfp_checker.sv
tb/lidar_scan_frame_parser_top_tb.sv
